@@ design/tpt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared widths, command codes, sine table and quadrant fold for the turtle
// pose tracker.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int POS_W     = 40;
    localparam int FRAC_BITS = 16;
    localparam int AMOUNT_W  = 14;
    localparam int HEAD_W    = 9;
    localparam int SINE_FRAC = 30;
    localparam int SINE_W    = SINE_FRAC + 1;
    localparam int SINE_N    = 91;
    localparam int IDX_W     = 7;

    localparam int FULL_TURN    = 360;
    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;
    localparam int THREE_QUARTER_TURN = 270;

    // amount mod 360 by reciprocal: q = (amount * MOD_RECIP) >> MOD_SHIFT
    // is the true quotient or one below it
    localparam int MOD_SHIFT = 23;
    localparam int MOD_RECIP = (1 << MOD_SHIFT) / FULL_TURN;
    localparam int RECIP_W   = $clog2(MOD_RECIP + 1);
    localparam int QUOT_W    = $clog2(((1 << AMOUNT_W) / FULL_TURN) + 1);

    localparam int TDATA_IN_W  = 16;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 256;
    localparam int TUSER_OUT_W = 2;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << SINE_FRAC;

    typedef enum logic [1:0] {
        CMD_RIGHT   = 2'd0,
        CMD_LEFT    = 2'd1,
        CMD_FORWARD = 2'd2,
        CMD_BAD     = 2'd3
    } cmd_t;

    typedef logic [SINE_N-1:0][SINE_W-1:0] sine_table_t;

    typedef struct packed {
        logic             neg;
        logic [IDX_W-1:0] idx;
    } sine_sel_t;

    // Integer Taylor series through the x^17 term, Q30, clamped to 0..1.
    function automatic sine_table_t sine_table_build();
        sine_table_t        tbl;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [64:0] sum;
        int                 d;
        int                 k;
        for (d = 0; d < SINE_N; d++) begin
            x    = (64'(d) * PI_Q30 + 64'(QUARTER_TURN)) / 64'(HALF_TURN);
            sum  = $signed({1'b0, x});
            term = x;
            for (k = 1; k <= 8; k++) begin
                term = (term * x) >> SINE_FRAC;
                term = (term * x) >> SINE_FRAC;
                term = term / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - $signed({1'b0, term});
                end else begin
                    sum = sum + $signed({1'b0, term});
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            if (sum > $signed({1'b0, ONE_Q30})) begin
                sum = $signed({1'b0, ONE_Q30});
            end
            tbl[d] = sum[SINE_W-1:0];
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = sine_table_build();

    // Fold a heading 0..359 onto the quarter-wave table.
    function automatic sine_sel_t sine_fold(input logic [HEAD_W-1:0] h);
        sine_sel_t         sel;
        logic [HEAD_W-1:0] t;
        if (h <= HEAD_W'(QUARTER_TURN)) begin
            t       = h;
            sel.neg = 1'b0;
        end else if (h <= HEAD_W'(HALF_TURN)) begin
            t       = HEAD_W'(HALF_TURN) - h;
            sel.neg = 1'b0;
        end else if (h <= HEAD_W'(THREE_QUARTER_TURN)) begin
            t       = h - HEAD_W'(HALF_TURN);
            sel.neg = 1'b1;
        end else begin
            t       = HEAD_W'(FULL_TURN) - h;
            sel.neg = 1'b1;
        end
        sel.idx = t[IDX_W-1:0];
        return sel;
    endfunction

endpackage
`default_nettype wire

@@ design/tpt_axis_move.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpt_axis_move
// One axis of a forward step: amount times signed sine, rounded to the
// position grid, added to the position with clamping at the range limits.
// ----------------------------------------------------------------------------
module tpt_axis_move (
    input  wire logic signed [tpt_pkg::POS_W-1:0]    pos,
    input  wire logic        [tpt_pkg::AMOUNT_W-1:0] amount,
    input  wire logic        [tpt_pkg::SINE_W-1:0]   sine_mag,
    input  wire logic                                sine_neg,
    input  wire logic                                move_en,
    output logic signed      [tpt_pkg::POS_W-1:0]    pos_new,
    output logic                                     sat
);
    import tpt_pkg::*;

    localparam int SHIFT   = SINE_FRAC - FRAC_BITS;
    localparam int MAG_W   = AMOUNT_W + SINE_W + 1;
    localparam int RND_W   = MAG_W - SHIFT;
    localparam int DELTA_W = RND_W + 1;
    localparam int SUM_W   = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 1;

    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (SHIFT - 1);
    localparam logic signed [SUM_W-1:0] POS_HI =
        SUM_W'($signed({1'b0, {(POS_W - 1){1'b1}}}));
    localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);

    logic        [MAG_W-1:0]   mag;
    logic        [RND_W-1:0]   rnd;
    logic signed [DELTA_W-1:0] delta;
    logic signed [SUM_W-1:0]   sum;

    always_comb begin
        mag   = MAG_W'(amount) * MAG_W'(sine_mag);
        rnd   = RND_W'((mag + HALF) >> SHIFT);
        delta = sine_neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
        sum   = SUM_W'(pos) + SUM_W'(delta);
        if (!move_en) begin
            pos_new = pos;
            sat     = 1'b0;
        end else if (sum > POS_HI) begin
            pos_new = POS_HI[POS_W-1:0];
            sat     = 1'b1;
        end else if (sum < POS_LO) begin
            pos_new = POS_LO[POS_W-1:0];
            sat     = 1'b1;
        end else begin
            pos_new = sum[POS_W-1:0];
            sat     = 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ design/turtle_pose_tracker_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// turtle_pose_tracker_top
// Turtle-graphics pose engine: heading, fixed-point position and bounding box.
// ----------------------------------------------------------------------------
// One command beat in gives one result beat out, carrying the pose and the
// bounding box after that command. A beat goes through two registers: the
// input register, which also reduces the amount mod 360, and the pose
// registers, which double as the result register. The block sustains one
// command per cycle while the result stream is not stalled; that rate is
// set by the pose update loop (heading and
// position feed back into themselves through the sine lookup, one multiply,
// rounding, a saturating add and the box compares). Positions carry 16
// fraction bits in 40 bits, two's complement; a forward move that would leave
// that range clamps at the limit and raises the saturated flag.
module turtle_pose_tracker_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [tpt_pkg::TDATA_IN_W-1:0]     s_tdata,  // amount[13:0], pad
    input  wire logic [tpt_pkg::TUSER_IN_W-1:0]     s_tuser,  // cmd[1:0]
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // pos_x[39:0], pos_y[79:40], heading_deg[88:80], box_min_x[128:89],
    // box_max_x[168:129], box_min_y[208:169], box_max_y[248:209], pad
    output logic [tpt_pkg::TDATA_OUT_W-1:0]         m_tdata,
    output logic [tpt_pkg::TUSER_OUT_W-1:0]         m_tuser   // bad_command, saturated
);
    import tpt_pkg::*;

    localparam int PAD_OUT_W = TDATA_OUT_W - (6 * POS_W + HEAD_W);
    localparam int MODW      = AMOUNT_W + 1;

    // input register
    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    logic [AMOUNT_W-1:0] in_amount_reg;
    logic [HEAD_W-1:0]   in_turn_reg;

    // pose state, also the result register
    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  pos_x_reg, pos_y_reg;
    logic signed [POS_W-1:0]  min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [HEAD_W-1:0]        heading_reg;
    logic                     bad_reg, sat_reg;

    logic                     advance;
    logic                     in_take;

    // amount mod 360, computed ahead of the pose loop
    logic [AMOUNT_W+RECIP_W-1:0] quot_prod;
    logic [QUOT_W-1:0]           quot;
    logic [MODW-1:0]             rem_raw;
    logic [HEAD_W-1:0]           turn_next;

    // pose update
    logic [HEAD_W:0]          head_sum;
    logic [HEAD_W-1:0]        heading_next;
    logic [HEAD_W:0]          cos_sum;
    logic [HEAD_W-1:0]        cos_head;
    sine_sel_t                sin_sel, cos_sel;
    logic                     move_en;
    logic signed [POS_W-1:0]  pos_x_next, pos_y_next;
    logic                     sat_x, sat_y;

    // advance the pose when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb begin
        quot_prod = (AMOUNT_W + RECIP_W)'(s_tdata[AMOUNT_W-1:0])
                  * (AMOUNT_W + RECIP_W)'(MOD_RECIP);
        quot      = QUOT_W'(quot_prod >> MOD_SHIFT);
        rem_raw   = MODW'(s_tdata[AMOUNT_W-1:0]) - MODW'(quot) * MODW'(FULL_TURN);
        // one correction step covers a quotient one short
        if (rem_raw >= MODW'(FULL_TURN)) begin
            turn_next = HEAD_W'(rem_raw - MODW'(FULL_TURN));
        end else begin
            turn_next = HEAD_W'(rem_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_cmd_reg    <= cmd_t'(s_tuser);
            in_amount_reg <= s_tdata[AMOUNT_W-1:0];
            in_turn_reg   <= turn_next;
        end
    end

    always_comb begin
        unique case (in_cmd_reg)
            CMD_RIGHT: head_sum = (HEAD_W + 1)'(heading_reg) + (HEAD_W + 1)'(in_turn_reg);
            CMD_LEFT:  head_sum = (HEAD_W + 1)'(heading_reg) + (HEAD_W + 1)'(FULL_TURN)
                                - (HEAD_W + 1)'(in_turn_reg);
            default:   head_sum = (HEAD_W + 1)'(heading_reg);
        endcase
        if (head_sum >= (HEAD_W + 1)'(FULL_TURN)) begin
            heading_next = HEAD_W'(head_sum - (HEAD_W + 1)'(FULL_TURN));
        end else begin
            heading_next = HEAD_W'(head_sum);
        end

        // cosine is the sine a quarter turn ahead
        cos_sum = (HEAD_W + 1)'(heading_reg) + (HEAD_W + 1)'(QUARTER_TURN);
        if (cos_sum >= (HEAD_W + 1)'(FULL_TURN)) begin
            cos_head = HEAD_W'(cos_sum - (HEAD_W + 1)'(FULL_TURN));
        end else begin
            cos_head = HEAD_W'(cos_sum);
        end
        sin_sel = sine_fold(heading_reg);
        cos_sel = sine_fold(cos_head);
        move_en = (in_cmd_reg == CMD_FORWARD);
    end

    tpt_axis_move u_move_x (
        .pos      (pos_x_reg),
        .amount   (in_amount_reg),
        .sine_mag (SINE_TABLE[sin_sel.idx]),
        .sine_neg (sin_sel.neg),
        .move_en  (move_en),
        .pos_new  (pos_x_next),
        .sat      (sat_x)
    );

    tpt_axis_move u_move_y (
        .pos      (pos_y_reg),
        .amount   (in_amount_reg),
        .sine_mag (SINE_TABLE[cos_sel.idx]),
        .sine_neg (cos_sel.neg),
        .move_en  (move_en),
        .pos_new  (pos_y_next),
        .sat      (sat_y)
    );

    // pose, box and flags; the box follows every position reached
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            heading_reg   <= '0;
            bad_reg       <= 1'b0;
            sat_reg       <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                heading_reg   <= heading_next;
                bad_reg       <= (in_cmd_reg == CMD_BAD);
                sat_reg       <= sat_x || sat_y;
                if (pos_x_next < min_x_reg) begin
                    min_x_reg <= pos_x_next;
                end
                if (pos_x_next > max_x_reg) begin
                    max_x_reg <= pos_x_next;
                end
                if (pos_y_next < min_y_reg) begin
                    min_y_reg <= pos_y_next;
                end
                if (pos_y_next > max_y_reg) begin
                    max_y_reg <= pos_y_next;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_OUT_W{1'b0}}, max_y_reg, min_y_reg, max_x_reg, min_x_reg,
                       heading_reg, pos_y_reg, pos_x_reg};
    assign m_tuser  = {sat_reg, bad_reg};

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_heading_range : assert property (@(posedge aclk) disable iff (!aresetn)
        heading_reg < HEAD_W'(FULL_TURN))
        else $error("heading out of range");

    a_box_holds_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        min_x_reg <= pos_x_reg && pos_x_reg <= max_x_reg &&
        min_y_reg <= pos_y_reg && pos_y_reg <= max_y_reg)
        else $error("bounding box misses current position");

    a_box_holds_origin : assert property (@(posedge aclk) disable iff (!aresetn)
        min_x_reg <= 0 && max_x_reg >= 0 && min_y_reg <= 0 && max_y_reg >= 0)
        else $error("bounding box misses origin");

    a_flags_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        !(bad_reg && sat_reg))
        else $error("bad command and saturation together");

    a_stall_holds_pose : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(pos_x_reg) && $stable(heading_reg))
        else $error("pose moved while result stalled");

endmodule
`default_nettype wire
